@@ design/xibd_pkg.sv @@
// Package: shared types, constants and opcode class table for the byte decoder.
package xibd_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SEGMENT = 3'd1;
    localparam logic [2:0] ST_LOCK    = 3'd2;
    localparam logic [2:0] ST_UNHAND  = 3'd3;
    localparam logic [2:0] ST_ESCAPE  = 3'd4;
    localparam logic [2:0] ST_LONG    = 3'd5;

    localparam logic [2:0] IK_NONE = 3'd0;
    localparam logic [2:0] IK_8    = 3'd1;
    localparam logic [2:0] IK_16   = 3'd2;
    localparam logic [2:0] IK_32   = 3'd3;
    localparam logic [2:0] IK_V    = 3'd4;
    localparam logic [2:0] IK_VQ   = 3'd5;

    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_NE   = 2'd1;
    localparam logic [1:0] REP_E    = 2'd2;

    typedef enum logic [5:0] {
        PH_PREFIX = 6'b000001,
        PH_MODRM  = 6'b000010,
        PH_SIB    = 6'b000100,
        PH_DISP8  = 6'b001000,
        PH_DISP32 = 6'b010000,
        PH_IMM    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic        modrm;
        logic [2:0]  kind;
    } t_class;

    // One instruction byte handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
    } t_fq_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  opcode;
        logic [7:0]  rex_byte;
        logic        operand_override;
        logic        address_override;
        logic [1:0]  rep_kind;
        logic [7:0]  modrm_value;
        logic [7:0]  sib_value;
        logic [31:0] displacement;
        logic [63:0] immediate;
        logic [3:0]  imm_bytes;
        logic [3:0]  length;
    } t_result;

    function automatic t_class op_class(input logic [7:0] op);
        t_class c;
        c = '{valid: 1'b0, modrm: 1'b0, kind: IK_NONE};
        if (op < 8'h40 && op[7:4] != 4'h1) begin
            if (op[2:0] <= 3'd3)      c = '{1'b1, 1'b1, IK_NONE};
            else if (op[2:0] == 3'd4) c = '{1'b1, 1'b0, IK_8};
            else if (op[2:0] == 3'd5) c = '{1'b1, 1'b0, IK_V};
        end else if (op[7:4] == 4'h5) c = '{1'b1, 1'b0, IK_NONE};
        else if (op[7:4] == 4'h7)     c = '{1'b1, 1'b0, IK_8};
        else if (op >= 8'h84 && op <= 8'h8B) c = '{1'b1, 1'b1, IK_NONE};
        else if (op >= 8'h90 && op <= 8'h97) c = '{1'b1, 1'b0, IK_NONE};
        else if (op >= 8'hB8) begin
            if (op <= 8'hBF) c = '{1'b1, 1'b0, IK_VQ};
            else begin
                case (op)
                    8'hFE, 8'hFF: c = '{1'b1, 1'b1, IK_NONE};
                    8'hEB: c = '{1'b1, 1'b0, IK_8};
                    8'hC7: c = '{1'b1, 1'b1, IK_V};
                    8'hC3, 8'hC9: c = '{1'b1, 1'b0, IK_NONE};
                    8'hC2: c = '{1'b1, 1'b0, IK_16};
                    8'hE8, 8'hE9: c = '{1'b1, 1'b0, IK_32};
                    default: c = '{valid: 1'b0, modrm: 1'b0, kind: IK_NONE};
                endcase
            end
        end else begin
            case (op)
                8'h63, 8'h8D, 8'h8F: c = '{1'b1, 1'b1, IK_NONE};
                8'h68: c = '{1'b1, 1'b0, IK_V};
                8'h6A: c = '{1'b1, 1'b0, IK_8};
                8'h80, 8'h83: c = '{1'b1, 1'b1, IK_8};
                8'h81: c = '{1'b1, 1'b1, IK_V};
                8'hAA, 8'hAB: c = '{1'b1, 1'b0, IK_NONE};
                default: c = '{valid: 1'b0, modrm: 1'b0, kind: IK_NONE};
            endcase
        end
        return c;
    endfunction

    function automatic logic [3:0] imm_size(input logic [2:0] kind, input logic o16,
                                            input logic w);
        logic [3:0] n;
        case (kind)
            IK_8:    n = 4'd1;
            IK_16:   n = 4'd2;
            IK_32:   n = 4'd4;
            IK_V:    n = o16 ? 4'd2 : 4'd4;
            IK_VQ:   n = w ? 4'd8 : (o16 ? 4'd2 : 4'd4);
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/xibd_front.sv @@
// Front part: input skid queue of instruction bytes feeding the decoder.
module xibd_front
    import xibd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_instr_byte,
    output logic       o_full,
    output logic       o_valid,
    output t_fq_item   o_item,
    input  logic       i_take
);
    // Two-entry queue so each side stalls on its own.
    logic [7:0] r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = '{data: r_mem[r_rp]};
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_instr_byte;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt != 2'd0) else $error("full queue emptied too fast");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("pointers disagree with count");
`endif
endmodule

@@ design/xibd_back.sv @@
// Back part: per-byte instruction state machine and result register.
module xibd_back
    import xibd_pkg::*;
#(
    parameter int MAX_LEN = 15
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_fq_item i_item,
    output logic    o_take,
    output logic    o_empty,
    output t_result o_res,
    input  logic    i_pop
);
    localparam logic [3:0] LenLimit = 4'(MAX_LEN);

    t_phase     r_phase, n_phase;
    logic [1:0] r_pf, n_pf;
    logic [7:0] r_rex, n_rex, r_op, n_op, r_modrm, n_modrm, r_sib, n_sib;
    logic [1:0] r_rep, n_rep;
    logic [31:0] r_disp, n_disp;
    logic [2:0] r_dleft, n_dleft;
    logic [63:0] r_imm, n_imm;
    logic [3:0] r_ileft, n_ileft, r_cnt, n_cnt;
    logic       r_full;
    t_result    r_res, n_res;

    logic [7:0] b;
    logic [3:0] len, isz_cur, isz_new;
    logic       done, emit;
    logic [2:0] est;
    logic [7:0] eop;
    t_class     cl, cl_cur, cl_out;
    logic [1:0] md;

    assign o_take  = i_valid && (!r_full || i_pop);
    assign o_empty = !r_full;
    assign o_res   = r_res;
    assign b       = i_item.data;
    assign len     = r_cnt + 4'd1;
    assign cl      = op_class(b);
    assign cl_cur  = op_class(r_op);
    assign isz_cur = imm_size(cl_cur.kind, r_pf[0], r_rex[3]);
    assign isz_new = imm_size(cl.kind, r_pf[0], r_rex[3]);
    assign md      = r_modrm[7:6];

    always_comb begin
        n_phase = r_phase; n_pf = r_pf; n_rex = r_rex; n_op = r_op;
        n_modrm = r_modrm; n_sib = r_sib; n_rep = r_rep; n_disp = r_disp;
        n_dleft = r_dleft; n_imm = r_imm; n_ileft = r_ileft; n_cnt = len;
        done = 1'b0; emit = 1'b0; est = ST_OK; eop = r_op;
        case (r_phase)
            PH_PREFIX: begin
                if (b[7:4] == 4'h4) n_rex = b;
                else begin
                    case (b)
                        8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65: begin
                            emit = 1'b1; est = ST_SEGMENT; eop = b;
                        end
                        8'hF0: begin emit = 1'b1; est = ST_LOCK; eop = b; end
                        8'h0F: begin emit = 1'b1; est = ST_ESCAPE; eop = b; end
                        8'h66: n_pf[0] = 1'b1;
                        8'h67: n_pf[1] = 1'b1;
                        8'hF2: n_rep = REP_NE;
                        8'hF3: n_rep = REP_E;
                        default: begin
                            if (!cl.valid) begin
                                emit = 1'b1; est = ST_UNHAND; eop = b;
                            end else begin
                                n_op = b;
                                if (cl.modrm) n_phase = PH_MODRM;
                                else if (isz_new == 4'd0) done = 1'b1;
                                else begin n_phase = PH_IMM; n_ileft = isz_new; end
                            end
                        end
                    endcase
                end
            end
            PH_MODRM: begin
                n_modrm = b;
                if (b[7:6] == 2'd3) begin
                    if (isz_cur == 4'd0) done = 1'b1;
                    else begin n_phase = PH_IMM; n_ileft = isz_cur; end
                end else if (b[2:0] == 3'd4) n_phase = PH_SIB;
                else if (b[7:6] == 2'd1) begin n_phase = PH_DISP8; n_dleft = 3'd1; end
                else if (b[7:6] == 2'd2 || b[2:0] == 3'd5) begin
                    n_phase = PH_DISP32; n_dleft = 3'd4;
                end else if (isz_cur == 4'd0) done = 1'b1;
                else begin n_phase = PH_IMM; n_ileft = isz_cur; end
            end
            PH_SIB: begin
                n_sib = b;
                if (md == 2'd1) begin n_phase = PH_DISP8; n_dleft = 3'd1; end
                else if (md == 2'd2 || (md == 2'd0 && b[2:0] == 3'd5)) begin
                    n_phase = PH_DISP32; n_dleft = 3'd4;
                end else if (isz_cur == 4'd0) done = 1'b1;
                else begin n_phase = PH_IMM; n_ileft = isz_cur; end
            end
            PH_DISP8: begin
                n_disp = {{24{b[7]}}, b};
                n_dleft = 3'd0;
                if (isz_cur == 4'd0) done = 1'b1;
                else begin n_phase = PH_IMM; n_ileft = isz_cur; end
            end
            PH_DISP32: begin
                n_disp = r_disp | (32'(b) << {3'(3'd4 - r_dleft) & 3'd3, 3'b000});
                n_dleft = r_dleft - 3'd1;
                if (r_dleft == 3'd1) begin
                    if (isz_cur == 4'd0) done = 1'b1;
                    else begin n_phase = PH_IMM; n_ileft = isz_cur; end
                end
            end
            PH_IMM: begin
                n_imm = r_imm | (64'(b) << {3'(isz_cur - r_ileft), 3'b000});
                n_ileft = r_ileft - 4'd1;
                if (r_ileft == 4'd1) done = 1'b1;
            end
            default: n_phase = PH_PREFIX;
        endcase
        // A completed or overlong instruction reports the opcode taken so far,
        // including one taken on this very byte.
        if (done) begin
            emit = 1'b1; eop = n_op;
        end else if (!emit && len >= LenLimit) begin
            emit = 1'b1; est = ST_LONG; eop = n_op;
        end

        cl_out = op_class(n_op);

        n_res.status           = est;
        n_res.opcode           = eop;
        n_res.rex_byte         = n_rex;
        n_res.operand_override = n_pf[0];
        n_res.address_override = n_pf[1];
        n_res.rep_kind         = n_rep;
        n_res.modrm_value      = (est == ST_OK) ? n_modrm : 8'd0;
        n_res.sib_value        = (est == ST_OK) ? n_sib : 8'd0;
        n_res.displacement     = (est == ST_OK) ? n_disp : 32'd0;
        n_res.immediate        = (est == ST_OK) ? n_imm : 64'd0;
        n_res.imm_bytes        = (est == ST_OK) ? imm_size(cl_out.kind,
                                                           n_pf[0], n_rex[3]) : 4'd0;
        n_res.length           = len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && emit)) begin
            r_phase <= PH_PREFIX; r_pf <= '0; r_rex <= '0; r_op <= '0;
            r_modrm <= '0; r_sib <= '0; r_rep <= '0; r_disp <= '0;
            r_dleft <= '0; r_imm <= '0; r_ileft <= '0; r_cnt <= '0;
        end else if (o_take) begin
            r_phase <= n_phase; r_pf <= n_pf; r_rex <= n_rex; r_op <= n_op;
            r_modrm <= n_modrm; r_sib <= n_sib; r_rep <= n_rep; r_disp <= n_disp;
            r_dleft <= n_dleft; r_imm <= n_imm; r_ileft <= n_ileft; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (o_take && emit) r_full <= 1'b1;
        else if (i_pop) r_full <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < LenLimit) else $error("byte count reached limit without a result");
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && emit) |=> (r_cnt == 4'd0 && r_phase == PH_PREFIX))
        else $error("state not cleared after a result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_pop) |=> r_full) else $error("result lost while stalled");
`endif
endmodule

@@ design/x86_64_instruction_byte_decoder_core.sv @@
// Top level: x86-64 instruction length decoder, one byte per cycle when not stalled.
//
//  channel | direction | handshake        | payload
//  bytes   | in        | i_push / o_full  | i_instr_byte
//  results | out       | o_empty / i_pop  | o_status ... o_length
//
// Each byte makes one step of the decoder state machine; with no stalls the
// sustained rate is one byte per cycle, set by the per-byte phase update.
// A result is registered on the transfer of the byte that finishes an instruction
// and is on the output ports in the next cycle.
// Reset clears the phase, collected prefixes and both queues.
// A full result register that is not popped stalls the decoder; a stalled decoder
// fills the two-entry input queue, which then raises o_full.
module x86_64_instruction_byte_decoder_core
    import xibd_pkg::*;
#(
    parameter int MAX_LEN = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_instr_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_opcode,
    output logic [7:0]  o_rex_byte,
    output logic        o_operand_override,
    output logic        o_address_override,
    output logic [1:0]  o_rep_kind,
    output logic [7:0]  o_modrm_value,
    output logic [7:0]  o_sib_value,
    output logic signed [31:0] o_displacement,
    output logic [63:0] o_immediate,
    output logic [3:0]  o_imm_bytes,
    output logic [3:0]  o_length
);
    logic     w_valid, w_take;
    t_fq_item w_item;
    t_result  w_res;

    xibd_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_instr_byte, .o_full,
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    xibd_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_item(w_item), .o_take(w_take),
        .o_empty, .o_res(w_res), .i_pop
    );

    assign o_status           = w_res.status;
    assign o_opcode           = w_res.opcode;
    assign o_rex_byte         = w_res.rex_byte;
    assign o_operand_override = w_res.operand_override;
    assign o_address_override = w_res.address_override;
    assign o_rep_kind         = w_res.rep_kind;
    assign o_modrm_value      = w_res.modrm_value;
    assign o_sib_value        = w_res.sib_value;
    assign o_displacement     = w_res.displacement;
    assign o_immediate        = w_res.immediate;
    assign o_imm_bytes        = w_res.imm_bytes;
    assign o_length           = w_res.length;
endmodule
